>>> src/ple_pkg.sv
// shared constants, payload types and codes for the positional list engine
package ple_pkg;

    localparam int DEPTH  = 32;
    localparam int POS_W  = 6;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_DUMP   = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic [1:0]              command;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] element;
        logic [1:0]              status;
        logic                    last;
    } rsp_t;

endpackage

>>> src/ple_rsp_reg.sv
// output holding register for result transfers
module ple_rsp_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  ple_pkg::rsp_t load_rsp,
    input  logic          rsp_ready,
    output logic          rsp_valid,
    output ple_pkg::rsp_t rsp,
    output logic          free
);

    logic          valid_reg;
    logic          valid_next;
    ple_pkg::rsp_t data_reg;

    // slot can take a new result at this edge if empty or being drained
    assign free = !valid_reg || rsp_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (rsp_ready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_rsp;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = data_reg;

endmodule

>>> src/positional_list_engine.sv
// top level: element store, shift sequencer and dump streamer
//
//  channel | direction | signals                  | payload
//  req     | in        | req_valid, req_ready     | command, position, value
//  rsp     | out       | rsp_valid, rsp_ready     | element, status, last
//
// insert moves each element at or above the position up one place, delete moves each
// element above it down one; the store, never read and written at once, moves one entry per read/write state pair
// dump gives one element per read and capture state pair while rsp_ready stays high
// reset clears the element count, the sequencer state and the result valid flag; store contents are not cleared
// a new request is taken only when the sequencer is idle, even with a result pending
// rsp_ready low holds the sequencer at its next result
module positional_list_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ple_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ple_pkg::rsp_t rsp
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SH_RD  = 6'b000010,
        S_SH_WR  = 6'b000100,
        S_FINISH = 6'b001000,
        S_DP_RD  = 6'b010000,
        S_DP_CAP = 6'b100000
    } state_t;

    state_t                               state_reg;
    state_t                               state_next;
    logic [ple_pkg::CNT_W-1:0]            count_reg;
    logic [ple_pkg::CNT_W-1:0]            count_next;
    logic [ple_pkg::CNT_W-1:0]            ptr_reg;
    logic [ple_pkg::CNT_W-1:0]            ptr_next;
    logic [ple_pkg::CNT_W-1:0]            tgt_reg;
    logic [ple_pkg::CNT_W-1:0]            tgt_next;
    logic                                 ins_reg;
    logic                                 ins_next;
    logic [1:0]                           status_reg;
    logic [1:0]                           status_next;
    logic signed [ple_pkg::VAL_W-1:0]     val_reg;
    logic signed [ple_pkg::VAL_W-1:0]     val_next;

    logic signed [ple_pkg::VAL_W-1:0]     store_reg [ple_pkg::DEPTH];
    logic signed [ple_pkg::VAL_W-1:0]     rd_data_reg;
    logic                                 rd_en;
    logic [ple_pkg::ADDR_W-1:0]           rd_addr;
    logic                                 wr_en;
    logic [ple_pkg::ADDR_W-1:0]           wr_addr;
    logic signed [ple_pkg::VAL_W-1:0]     wr_data;

    logic                                 rsp_load;
    ple_pkg::rsp_t                        rsp_load_data;
    logic                                 rsp_free;

    logic                                 req_xfer;
    logic [ple_pkg::CMP_W-1:0]            pos_ext;
    logic [ple_pkg::CMP_W-1:0]            cnt_ext;
    logic [ple_pkg::CNT_W-1:0]            ptr_inc;
    logic [ple_pkg::CNT_W-1:0]            ptr_dec;
    logic [ple_pkg::CNT_W-1:0]            cnt_dec;

    assign req_ready = (state_reg == S_IDLE);
    assign req_xfer  = req_valid && req_ready;
    assign pos_ext   = ple_pkg::CMP_W'(req.position);
    assign cnt_ext   = ple_pkg::CMP_W'(count_reg);
    assign ptr_inc   = ptr_reg + ple_pkg::CNT_W'(1);
    assign ptr_dec   = ptr_reg - ple_pkg::CNT_W'(1);
    assign cnt_dec   = count_reg - ple_pkg::CNT_W'(1);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        tgt_next      = tgt_reg;
        ins_next      = ins_reg;
        status_next   = status_reg;
        val_next      = val_reg;
        rd_en         = 1'b0;
        rd_addr       = ptr_reg[ple_pkg::ADDR_W-1:0];
        wr_en         = 1'b0;
        wr_addr       = ptr_reg[ple_pkg::ADDR_W-1:0];
        wr_data       = rd_data_reg;
        rsp_load      = 1'b0;
        rsp_load_data = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    val_next = req.value;
                    case (req.command)
                        ple_pkg::CMD_INSERT:
                        begin
                            ins_next = 1'b1;
                            if (count_reg == ple_pkg::CNT_W'(ple_pkg::DEPTH))
                            begin
                                status_next = ple_pkg::ST_FULL;
                                state_next  = S_FINISH;
                            end
                            else
                            begin
                                // a position past the end appends
                                tgt_next    = (pos_ext > cnt_ext) ? count_reg
                                                                  : ple_pkg::CNT_W'(pos_ext);
                                ptr_next    = count_reg;
                                status_next = ple_pkg::ST_OK;
                                state_next  = S_SH_RD;
                            end
                        end
                        ple_pkg::CMD_DELETE:
                        begin
                            ins_next = 1'b0;
                            if (pos_ext >= cnt_ext)
                            begin
                                status_next = ple_pkg::ST_BADPOS;
                                state_next  = S_FINISH;
                            end
                            else
                            begin
                                ptr_next    = ple_pkg::CNT_W'(pos_ext);
                                status_next = ple_pkg::ST_OK;
                                state_next  = S_SH_RD;
                            end
                        end
                        ple_pkg::CMD_DUMP:
                        begin
                            ptr_next = '0;
                            if (count_reg == '0)
                            begin
                                status_next = ple_pkg::ST_EMPTY;
                                state_next  = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_DP_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SH_RD:
            begin
                if (ins_reg)
                begin
                    if (ptr_reg == tgt_reg)
                    begin
                        wr_en      = 1'b1;
                        wr_data    = val_reg;
                        count_next = count_reg + ple_pkg::CNT_W'(1);
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = ptr_dec[ple_pkg::ADDR_W-1:0];
                        state_next = S_SH_WR;
                    end
                end
                else
                begin
                    if (ptr_inc < count_reg)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = ptr_inc[ple_pkg::ADDR_W-1:0];
                        state_next = S_SH_WR;
                    end
                    else
                    begin
                        count_next = cnt_dec;
                        state_next = S_FINISH;
                    end
                end
            end

            S_SH_WR:
            begin
                wr_en      = 1'b1;
                ptr_next   = ins_reg ? ptr_dec : ptr_inc;
                state_next = S_SH_RD;
            end

            S_FINISH:
            begin
                if (rsp_free)
                begin
                    rsp_load             = 1'b1;
                    rsp_load_data.status = status_reg;
                    rsp_load_data.last   = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            S_DP_RD:
            begin
                // only read once the result slot is sure to be empty at capture
                if (rsp_free)
                begin
                    rd_en      = 1'b1;
                    state_next = S_DP_CAP;
                end
            end

            S_DP_CAP:
            begin
                rsp_load              = 1'b1;
                rsp_load_data.element = rd_data_reg;
                rsp_load_data.status  = ple_pkg::ST_OK;
                rsp_load_data.last    = (ptr_reg == cnt_dec);
                if (ptr_reg == cnt_dec)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next   = ptr_inc;
                    state_next = S_DP_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        tgt_reg    <= tgt_next;
        ins_reg    <= ins_next;
        status_reg <= status_next;
        val_reg    <= val_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    ple_rsp_reg u_rsp_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (rsp_load),
        .load_rsp  (rsp_load_data),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .free      (rsp_free)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ple_pkg::CNT_W'(ple_pkg::DEPTH))
        else $error("element count above depth");

    a_wr_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_SH_RD || state_reg == S_SH_WR))
        else $error("store write outside shift sequence");

    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != count_next) |-> (state_reg == S_SH_RD && state_next == S_FINISH))
        else $error("element count changed outside end of shift");

    a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_xfer && (req.command == ple_pkg::CMD_INSERT ||
                      req.command == ple_pkg::CMD_DELETE ||
                      req.command == ple_pkg::CMD_DUMP)) |=> (state_reg != S_IDLE))
        else $error("accepted command left sequencer idle");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_load && rsp_valid) |-> rsp_ready)
        else $error("result overwritten before transfer");

endmodule

>>> bench/positional_list_engine_tb.sv
// self-checking testbench for the positional list engine: directed table then random episodes
`timescale 1ns / 1ps

module positional_list_engine_tb;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         RAND_ITEMS  = 330;
    localparam int         CYCLE_LIMIT = 600000;
    localparam int         SETTLE      = 200;
    localparam int         PRINT_CAP   = 50;

    typedef enum int {EP_MIX, EP_FILL, EP_DRAIN} episode_t;

    typedef struct {
        ple_pkg::req_t item;
        bit            typed;
        ple_pkg::rsp_t want;
    } dir_row_t;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_ready;
    ple_pkg::req_t req       = '0;
    logic          rsp_valid;
    logic          rsp_ready = 1'b0;
    ple_pkg::rsp_t rsp;

    // predictor state: the list as the block should hold it
    logic signed [ple_pkg::VAL_W-1:0] list_mem [ple_pkg::DEPTH];
    int                               list_len = 0;
    ple_pkg::rsp_t                    pending_rsp [$];
    dir_row_t                         dir_rows [$];
    ple_pkg::rsp_t                    want_rsp;

    bit calm = 1'b0;
    int mismatches = 0;
    int cycle_count = 0;
    int n_insert = 0, n_full = 0, n_delete = 0, n_badpos = 0;
    int n_dump = 0, n_empty = 0, n_results = 0, n_ignored = 0;

    positional_list_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_rsp.size());
            $display("FAIL positional_list_engine");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        rsp_ready <= calm || ($urandom_range(0, 99) >= 10);
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch at cycle %0d: %0s got %h expected %h", cycle_count, what,
                     got, want);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            n_results++;
            if (pending_rsp.size() == 0)
                report_mismatch("unexpected result", rsp.element, '0);
            else
            begin
                want_rsp = pending_rsp.pop_front();
                if (rsp.element !== want_rsp.element)
                    report_mismatch("element", rsp.element, want_rsp.element);
                if (rsp.status !== want_rsp.status)
                    report_mismatch("status", 32'(rsp.status), 32'(want_rsp.status));
                if (rsp.last !== want_rsp.last)
                    report_mismatch("last", 32'(rsp.last), 32'(want_rsp.last));
            end
        end
    end

    // apply one accepted command to the predicted list, queue what it should produce
    function automatic void apply_list_cmd(input ple_pkg::req_t item, input bit push);
        ple_pkg::rsp_t r;
        int            at;
        r      = '0;
        r.last = 1'b1;
        case (item.command)
            ple_pkg::CMD_INSERT:
            begin
                n_insert++;
                if (list_len >= ple_pkg::DEPTH)
                begin
                    r.status = ple_pkg::ST_FULL;
                    n_full++;
                end
                else
                begin
                    at = (int'(item.position) > list_len) ? list_len : int'(item.position);
                    for (int i = list_len; i > at; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[at] = item.value;
                    list_len++;
                    r.status = ple_pkg::ST_OK;
                end
                if (push)
                    pending_rsp.push_back(r);
            end
            ple_pkg::CMD_DELETE:
            begin
                n_delete++;
                if (int'(item.position) >= list_len)
                begin
                    r.status = ple_pkg::ST_BADPOS;
                    n_badpos++;
                end
                else
                begin
                    for (int i = int'(item.position); i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                    r.status = ple_pkg::ST_OK;
                end
                if (push)
                    pending_rsp.push_back(r);
            end
            ple_pkg::CMD_DUMP:
            begin
                n_dump++;
                if (list_len == 0)
                begin
                    n_empty++;
                    r.status = ple_pkg::ST_EMPTY;
                    if (push)
                        pending_rsp.push_back(r);
                end
                else if (push)
                begin
                    for (int i = 0; i < list_len; i++)
                    begin
                        r.element = list_mem[i];
                        r.status  = ple_pkg::ST_OK;
                        r.last    = (i == list_len - 1);
                        pending_rsp.push_back(r);
                    end
                end
            end
            default:
                n_ignored++;
        endcase
    endfunction

    function automatic void add_row(input logic [1:0] cmd, input int pos,
                                    input logic [31:0] val, input bit typed,
                                    input logic [1:0] st);
        dir_row_t row;
        row.item.command  = cmd;
        row.item.position = ple_pkg::POS_W'(pos);
        row.item.value    = val;
        row.typed         = typed;
        row.want          = '0;
        row.want.status   = st;
        row.want.last     = 1'b1;
        dir_rows.push_back(row);
    endfunction

    function automatic logic [ple_pkg::POS_W-1:0] pick_position(input bit for_delete);
        int hi;
        hi = for_delete ? list_len - 1 : list_len;
        if (hi < 0 || $urandom_range(0, 99) < 30)
            return ple_pkg::POS_W'($urandom_range(0, ple_pkg::DEPTH));
        return ple_pkg::POS_W'($urandom_range(0, hi));
    endfunction

    function automatic logic [ple_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // present one request and hold it until the transfer
    task automatic send_req(input ple_pkg::req_t item);
        int gap;
        if (!calm && $urandom_range(0, 99) < 10)
        begin
            req_valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        ple_pkg::req_t item;
        episode_t      kind;
        int            len;
        int            rand_items;
        int            roll;
        bit            first_episode;

        rand_items    = 0;
        first_episode = 1'b1;

        add_row(ple_pkg::CMD_DUMP,    0, 32'h0,         1, ple_pkg::ST_EMPTY);  // empty dump
        add_row(ple_pkg::CMD_DELETE,  0, 32'h0,         1, ple_pkg::ST_BADPOS); // empty delete
        add_row(ple_pkg::CMD_DELETE, 32, 32'hdead_beef, 1, ple_pkg::ST_BADPOS);
        add_row(ple_pkg::CMD_INSERT,  0, 32'h7fff_ffff, 1, ple_pkg::ST_OK);
        add_row(ple_pkg::CMD_INSERT, 32, 32'h8000_0000, 1, ple_pkg::ST_OK); // far past end
        add_row(ple_pkg::CMD_INSERT,  1, 32'hffff_ffff, 0, ple_pkg::ST_OK);
        add_row(ple_pkg::CMD_INSERT,  0, 32'h0000_0000, 0, ple_pkg::ST_OK);
        add_row(ple_pkg::CMD_INSERT,  5, 32'h1234_5678, 1, ple_pkg::ST_OK); // length+1
        add_row(ple_pkg::CMD_INSERT,  2, 32'h5555_aaaa, 0, ple_pkg::ST_OK);
        add_row(ple_pkg::CMD_DUMP,    0, 32'h0,         0, ple_pkg::ST_OK);
        add_row(ple_pkg::CMD_DELETE,  6, 32'h0,         1, ple_pkg::ST_BADPOS); // at length
        add_row(ple_pkg::CMD_DELETE, 31, 32'h0,         1, ple_pkg::ST_BADPOS);
        add_row(ple_pkg::CMD_DELETE,  0, 32'h0,         0, ple_pkg::ST_OK);
        add_row(ple_pkg::CMD_DELETE,  4, 32'h0,         0, ple_pkg::ST_OK);
        add_row(ple_pkg::CMD_DUMP,    0, 32'h0,         0, ple_pkg::ST_OK);
        add_row(CMD_UNUSED,          17, 32'hdead_beef, 0, ple_pkg::ST_OK); // ignored
        add_row(ple_pkg::CMD_INSERT,  4, 32'h0000_0001, 0, ple_pkg::ST_OK); // at length
        add_row(ple_pkg::CMD_DUMP,    0, 32'h0,         0, ple_pkg::ST_OK);
        add_row(ple_pkg::CMD_DELETE,  2, 32'h0,         0, ple_pkg::ST_OK);
        add_row(ple_pkg::CMD_DELETE,  0, 32'h0,         0, ple_pkg::ST_OK);
        add_row(ple_pkg::CMD_DELETE,  0, 32'h0,         0, ple_pkg::ST_OK);
        add_row(ple_pkg::CMD_DELETE,  0, 32'h0,         0, ple_pkg::ST_OK);
        add_row(ple_pkg::CMD_DELETE,  0, 32'h0,         0, ple_pkg::ST_OK);
        add_row(ple_pkg::CMD_DUMP,    0, 32'h0,         1, ple_pkg::ST_EMPTY);
        add_row(ple_pkg::CMD_DELETE,  0, 32'h0,         1, ple_pkg::ST_BADPOS);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_req(dir_rows[i].item);
            apply_list_cmd(dir_rows[i].item, !dir_rows[i].typed);
            if (dir_rows[i].typed)
                pending_rsp.push_back(dir_rows[i].want);
        end
        drain_results();

        // episodes: fill to full and beyond, drain to empty and beyond, mixed traffic
        while (rand_items < RAND_ITEMS)
        begin
            if (first_episode)
                kind = EP_FILL;
            else
                kind = episode_t'($urandom_range(0, 2));
            first_episode = 1'b0;
            case (kind)
                EP_FILL:  len = ple_pkg::DEPTH - list_len + $urandom_range(2, 6);
                EP_DRAIN: len = list_len + $urandom_range(2, 5);
                default:  len = $urandom_range(15, 40);
            endcase
            for (int k = 0; k < len && rand_items < RAND_ITEMS; k++)
            begin
                roll = $urandom_range(0, 99);
                item.value    = pick_value();
                item.position = '0;
                case (kind)
                    EP_FILL:
                        item.command = (roll < 90) ? ple_pkg::CMD_INSERT : ple_pkg::CMD_DUMP;
                    EP_DRAIN:
                        item.command = (roll < 85) ? ple_pkg::CMD_DELETE : ple_pkg::CMD_DUMP;
                    default:
                        if (roll < 45)
                            item.command = ple_pkg::CMD_INSERT;
                        else if (roll < 80)
                            item.command = ple_pkg::CMD_DELETE;
                        else if (roll < 95)
                            item.command = ple_pkg::CMD_DUMP;
                        else
                            item.command = CMD_UNUSED;
                endcase
                if (item.command != ple_pkg::CMD_DUMP)
                    item.position = pick_position(item.command == ple_pkg::CMD_DELETE);
                calm = (rand_items >= 120 && rand_items < 200);
                send_req(item);
                apply_list_cmd(item, 1'b1);
                if (item.command != CMD_UNUSED)
                begin
                    rand_items++;
                    if (rand_items == 250)
                        drain_results();
                end
            end
        end

        calm = 1'b0;
        drain_results();
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d inserts (%0d full), %0d deletes (%0d bad position), %0d dumps",
                 n_insert, n_full, n_delete, n_badpos, n_dump);
        $display("%0d empty dumps, %0d ignored codes, %0d results checked, %0d mismatches",
                 n_empty, n_ignored, n_results, mismatches);
        if (mismatches == 0)
            $display("PASS positional_list_engine");
        else
            $display("FAIL positional_list_engine");
        $finish;
    end

endmodule

>>> positional_list_engine.f
src/ple_pkg.sv
src/ple_rsp_reg.sv
src/positional_list_engine.sv
bench/positional_list_engine_tb.sv
